FILE: hw/rtl/bcs_pkg.sv
// bcs_pkg: shared widths, codes and constants of the barometric compensation sequencer
// used by the serial multiplier, the top level and the port checker
package bcs_pkg;

    localparam int TICKS_PER_READ = 4;
    localparam int PHASE_W = (TICKS_PER_READ > 1) ? $clog2(TICKS_PER_READ) : 1;

    localparam int SAMPLE_W = 24;
    localparam int COEFF_W  = 16;
    localparam int OUT_W    = 32;
    localparam int ACT_W    = 2;
    localparam int CFG_IDX_W = 3;

    // serial multiplier: signed multiplicand, unsigned multiplier
    localparam int A_W    = 34;
    localparam int B_W    = SAMPLE_W;
    localparam int PROD_W = A_W + 1 + B_W;
    localparam int CNT_W  = $clog2(B_W);

    localparam int DT_W   = SAMPLE_W + 1;
    localparam int OFF_W  = 36;
    localparam int DIFF_W = 39;

    localparam int TEMP_BASE   = 2000;
    localparam int TEMP_SHIFT  = 23;
    localparam int OFF_SHIFT   = 7;
    localparam int SENS_SHIFT  = 8;
    localparam int P_SHIFT_HI  = 21;
    localparam int P_SHIFT_LO  = 15;
    localparam int C1_SHIFT    = 15;
    localparam int C2_SHIFT    = 16;
    localparam int C5_SHIFT    = 8;
    localparam int Q_W         = PROD_W - P_SHIFT_HI;

    localparam logic [ACT_W-1:0] ACT_HOLD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PRESS = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TEMP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SENS        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE  = 3'd5;

endpackage

FILE: hw/rtl/bcs_serial_mul.sv
// bcs_serial_mul: shift-add multiplier, one multiplier bit per cycle
// signed multiplicand times unsigned multiplier; depends on bcs_pkg
module bcs_serial_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bcs_pkg::A_W-1:0]      a,
    input  logic [bcs_pkg::B_W-1:0]      b,
    output logic                         done,
    output logic [bcs_pkg::PROD_W-1:0]   product
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [bcs_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [bcs_pkg::A_W-1:0]       a_reg, a_next;
    logic [bcs_pkg::A_W:0]         hi_reg, hi_next;
    logic [bcs_pkg::B_W-1:0]       lo_reg, lo_next;
    logic [bcs_pkg::A_W:0]         addend;
    logic [bcs_pkg::A_W:0]         sum;

    always_comb
    begin
        addend = lo_reg[0] ? {a_reg[bcs_pkg::A_W-1], a_reg} : '0;
        sum = hi_reg + addend;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        a_next     = a_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            a_next     = a;
            hi_next    = '0;
            lo_next    = b;
        end
        else if (busy_reg)
        begin
            // arithmetic shift of {sum, lo} right by one
            hi_next = {sum[bcs_pkg::A_W], sum[bcs_pkg::A_W:1]};
            lo_next = {sum[0], lo_reg[bcs_pkg::B_W-1:1]};
            count_next = count_reg + 1'b1;
            if (count_reg == bcs_pkg::CNT_W'(bcs_pkg::B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

FILE: hw/rtl/baro_compensation_sequencer.sv
// baro_compensation_sequencer: tick sequencer with first-order pressure and temperature compensation
// uses bcs_pkg and bcs_serial_mul (one bit-serial multiplier shared by four products)
// hold and temperature ticks go from ST_IDLE to ST_DONE and then into the output register
// pressure ticks first run four 24-step serial multiplications, in states ST_MUL_T to ST_MUL_P
// a new tick is accepted only in ST_IDLE, after the previous result has entered the output register
// reset: asynchronous active-low, clears coefficients, phase, raw and held values to zero
module baro_compensation_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bcs_pkg::COEFF_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bcs_pkg::SAMPLE_W-1:0]      raw_sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [bcs_pkg::OUT_W-1:0]  pressure,
    output logic signed [bcs_pkg::OUT_W-1:0]  temperature,
    output logic [bcs_pkg::ACT_W-1:0]         action
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_T = 3'd1;
    localparam logic [2:0] ST_MUL_O = 3'd2;
    localparam logic [2:0] ST_MUL_S = 3'd3;
    localparam logic [2:0] ST_MUL_P = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]                        state_reg, state_next;
    logic [bcs_pkg::PHASE_W-1:0]       phase_reg, phase_next;
    logic                              last_temp_reg, last_temp_next;
    logic [bcs_pkg::SAMPLE_W-1:0]      raw_p_reg, raw_p_next;
    logic [bcs_pkg::SAMPLE_W-1:0]      raw_t_reg, raw_t_next;
    logic [bcs_pkg::DT_W-1:0]          dt_reg, dt_next;
    logic [bcs_pkg::OFF_W-1:0]         off_reg, off_next;
    logic [bcs_pkg::A_W-1:0]           sens_reg, sens_next;
    logic [bcs_pkg::OUT_W-1:0]         held_p_reg, held_p_next;
    logic [bcs_pkg::OUT_W-1:0]         held_t_reg, held_t_next;
    logic [bcs_pkg::ACT_W-1:0]         act_reg, act_next;
    logic                              mul_start_reg, mul_start_next;
    logic                              out_valid_reg, out_valid_next;
    logic [bcs_pkg::OUT_W-1:0]         out_p_reg, out_p_next;
    logic [bcs_pkg::OUT_W-1:0]         out_t_reg, out_t_next;
    logic [bcs_pkg::ACT_W-1:0]         out_act_reg, out_act_next;

    logic [bcs_pkg::COEFF_W-1:0]       sens_coeff_reg, sens_coeff_next;
    logic [bcs_pkg::COEFF_W-1:0]       offset_coeff_reg, offset_coeff_next;
    logic [bcs_pkg::COEFF_W-1:0]       sens_temp_coeff_reg, sens_temp_coeff_next;
    logic [bcs_pkg::COEFF_W-1:0]       offset_temp_coeff_reg, offset_temp_coeff_next;
    logic [bcs_pkg::COEFF_W-1:0]       ref_temp_coeff_reg, ref_temp_coeff_next;
    logic [bcs_pkg::COEFF_W-1:0]       temp_slope_coeff_reg, temp_slope_coeff_next;

    logic [bcs_pkg::A_W-1:0]           mul_a;
    logic [bcs_pkg::B_W-1:0]           mul_b;
    logic                              mul_done;
    logic [bcs_pkg::PROD_W-1:0]        mul_product;

    logic                              in_xfer;
    logic [bcs_pkg::OUT_W-1:0]         temp_val;
    logic [bcs_pkg::OFF_W-1:0]         off_val;
    logic [bcs_pkg::A_W-1:0]           sens_val;
    logic [bcs_pkg::Q_W-1:0]           q_val;
    logic [bcs_pkg::DIFF_W-1:0]        diff_val;
    logic [bcs_pkg::OUT_W-1:0]         press_val;
    logic [bcs_pkg::DT_W-1:0]          dt_val;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;

    // configuration registers
    always_comb
    begin
        sens_coeff_next        = sens_coeff_reg;
        offset_coeff_next      = offset_coeff_reg;
        sens_temp_coeff_next   = sens_temp_coeff_reg;
        offset_temp_coeff_next = offset_temp_coeff_reg;
        ref_temp_coeff_next    = ref_temp_coeff_reg;
        temp_slope_coeff_next  = temp_slope_coeff_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bcs_pkg::REG_SENS:        sens_coeff_next        = cfg_data;
                bcs_pkg::REG_OFFSET:      offset_coeff_next      = cfg_data;
                bcs_pkg::REG_SENS_TEMP:   sens_temp_coeff_next   = cfg_data;
                bcs_pkg::REG_OFFSET_TEMP: offset_temp_coeff_next = cfg_data;
                bcs_pkg::REG_REF_TEMP:    ref_temp_coeff_next    = cfg_data;
                bcs_pkg::REG_TEMP_SLOPE:  temp_slope_coeff_next  = cfg_data;
                default: ;
            endcase
        end
    end

    // multiplier operands follow the step in progress
    always_comb
    begin
        mul_a = {{(bcs_pkg::A_W - bcs_pkg::DT_W){dt_reg[bcs_pkg::DT_W-1]}}, dt_reg};
        mul_b = bcs_pkg::B_W'(temp_slope_coeff_reg);
        unique case (state_reg)
            ST_MUL_O: mul_b = bcs_pkg::B_W'(offset_temp_coeff_reg);
            ST_MUL_S: mul_b = bcs_pkg::B_W'(sens_temp_coeff_reg);
            ST_MUL_P:
            begin
                mul_a = sens_reg;
                mul_b = raw_p_reg;
            end
            default: ;
        endcase
    end

    bcs_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    // scaling of each product; the shifts are floor shifts of the signed product
    always_comb
    begin
        dt_val = {1'b0, raw_t_reg}
               - {1'b0, ref_temp_coeff_reg, {bcs_pkg::C5_SHIFT{1'b0}}};
        temp_val = mul_product[bcs_pkg::TEMP_SHIFT+bcs_pkg::OUT_W-1:bcs_pkg::TEMP_SHIFT]
                 + bcs_pkg::OUT_W'(bcs_pkg::TEMP_BASE);
        off_val = mul_product[bcs_pkg::OFF_SHIFT+bcs_pkg::OFF_W-1:bcs_pkg::OFF_SHIFT]
                + bcs_pkg::OFF_W'({offset_coeff_reg, {bcs_pkg::C2_SHIFT{1'b0}}});
        sens_val = mul_product[bcs_pkg::SENS_SHIFT+bcs_pkg::A_W-1:bcs_pkg::SENS_SHIFT]
                 + bcs_pkg::A_W'({sens_coeff_reg, {bcs_pkg::C1_SHIFT{1'b0}}});
        q_val = mul_product[bcs_pkg::PROD_W-1:bcs_pkg::P_SHIFT_HI];
        diff_val = {{(bcs_pkg::DIFF_W - bcs_pkg::Q_W){q_val[bcs_pkg::Q_W-1]}}, q_val}
                 - {{(bcs_pkg::DIFF_W - bcs_pkg::OFF_W){off_reg[bcs_pkg::OFF_W-1]}}, off_reg};
        press_val = {{(bcs_pkg::OUT_W - (bcs_pkg::DIFF_W - bcs_pkg::P_SHIFT_LO))
                       {diff_val[bcs_pkg::DIFF_W-1]}},
                     diff_val[bcs_pkg::DIFF_W-1:bcs_pkg::P_SHIFT_LO]};
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        last_temp_next = last_temp_reg;
        raw_p_next     = raw_p_reg;
        raw_t_next     = raw_t_reg;
        dt_next        = dt_reg;
        off_next       = off_reg;
        sens_next      = sens_reg;
        held_p_next    = held_p_reg;
        held_t_next    = held_t_reg;
        act_next       = act_reg;
        mul_start_next = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_p_next     = out_p_reg;
        out_t_next     = out_t_reg;
        out_act_next   = out_act_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_DONE;
                    act_next   = bcs_pkg::ACT_HOLD;
                    if (phase_reg >= bcs_pkg::PHASE_W'(bcs_pkg::TICKS_PER_READ - 1))
                    begin
                        phase_next = '0;
                        if (!last_temp_reg)
                        begin
                            raw_p_next     = raw_sample;
                            last_temp_next = 1'b1;
                            act_next       = bcs_pkg::ACT_PRESS;
                            dt_next        = dt_val;
                            state_next     = ST_MUL_T;
                            mul_start_next = 1'b1;
                        end
                        else
                        begin
                            raw_t_next     = raw_sample;
                            last_temp_next = 1'b0;
                            act_next       = bcs_pkg::ACT_TEMP;
                        end
                    end
                    else
                    begin
                        phase_next = phase_reg + 1'b1;
                    end
                end
            end
            ST_MUL_T:
            begin
                if (mul_done)
                begin
                    held_t_next    = temp_val;
                    state_next     = ST_MUL_O;
                    mul_start_next = 1'b1;
                end
            end
            ST_MUL_O:
            begin
                if (mul_done)
                begin
                    off_next       = off_val;
                    state_next     = ST_MUL_S;
                    mul_start_next = 1'b1;
                end
            end
            ST_MUL_S:
            begin
                if (mul_done)
                begin
                    sens_next      = sens_val;
                    state_next     = ST_MUL_P;
                    mul_start_next = 1'b1;
                end
            end
            ST_MUL_P:
            begin
                if (mul_done)
                begin
                    held_p_next = press_val;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_p_next     = held_p_reg;
                    out_t_next     = held_t_reg;
                    out_act_next   = act_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            phase_reg             <= '0;
            last_temp_reg         <= 1'b0;
            raw_p_reg             <= '0;
            raw_t_reg             <= '0;
            held_p_reg            <= '0;
            held_t_reg            <= '0;
            mul_start_reg         <= 1'b0;
            out_valid_reg         <= 1'b0;
            sens_coeff_reg        <= '0;
            offset_coeff_reg      <= '0;
            sens_temp_coeff_reg   <= '0;
            offset_temp_coeff_reg <= '0;
            ref_temp_coeff_reg    <= '0;
            temp_slope_coeff_reg  <= '0;
        end
        else
        begin
            state_reg             <= state_next;
            phase_reg             <= phase_next;
            last_temp_reg         <= last_temp_next;
            raw_p_reg             <= raw_p_next;
            raw_t_reg             <= raw_t_next;
            held_p_reg            <= held_p_next;
            held_t_reg            <= held_t_next;
            mul_start_reg         <= mul_start_next;
            out_valid_reg         <= out_valid_next;
            sens_coeff_reg        <= sens_coeff_next;
            offset_coeff_reg      <= offset_coeff_next;
            sens_temp_coeff_reg   <= sens_temp_coeff_next;
            offset_temp_coeff_reg <= offset_temp_coeff_next;
            ref_temp_coeff_reg    <= ref_temp_coeff_next;
            temp_slope_coeff_reg  <= temp_slope_coeff_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg      <= dt_next;
        off_reg     <= off_next;
        sens_reg    <= sens_next;
        act_reg     <= act_next;
        out_p_reg   <= out_p_next;
        out_t_reg   <= out_t_next;
        out_act_reg <= out_act_next;
    end

    assign out_valid   = out_valid_reg;
    assign pressure    = out_p_reg;
    assign temperature = out_t_reg;
    assign action      = out_act_reg;

endmodule

FILE: hw/rtl/bcs_checker.sv
// bcs_checker: port-level assertions for baro_compensation_sequencer, attached by bind
// depends on bcs_pkg for widths and action codes
module bcs_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [bcs_pkg::OUT_W-1:0]  pressure,
    input  logic signed [bcs_pkg::OUT_W-1:0]  temperature,
    input  logic [bcs_pkg::ACT_W-1:0]         action
);

    logic [2:0]                 pending_reg, pending_next;
    logic [bcs_pkg::OUT_W-1:0]  last_p_reg, last_p_next;
    logic [bcs_pkg::OUT_W-1:0]  last_t_reg, last_t_next;
    logic                       in_xfer;
    logic                       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg + {2'b0, in_xfer} - {2'b0, out_xfer};
        last_p_next  = out_xfer ? pressure : last_p_reg;
        last_t_next  = out_xfer ? temperature : last_t_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            last_p_reg  <= '0;
            last_t_reg  <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            last_p_reg  <= last_p_next;
            last_t_reg  <= last_t_next;
        end
    end

    // at most one item in work and one waiting at the output
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("more than two items outstanding");

    // no result without a matching input transfer
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result shown with no item outstanding");

    // hold and temperature ticks repeat the last delivered values
    a_held_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && action != bcs_pkg::ACT_PRESS)
        |-> (pressure == last_p_reg && temperature == last_t_reg))
        else $error("held values changed without a pressure action");

    a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pressure)
                                       && $stable(temperature) && $stable(action)))
        else $error("stalled result changed");

endmodule

bind baro_compensation_sequencer bcs_checker u_bcs_checker (.*);

FILE: bench/baro_compensation_sequencer_checker.sv
// scoreboard for baro_compensation_sequencer: tracks coefficient writes and ticks, predicts
// every result and compares it with what leaves the output channel
// depends on bcs_pkg for widths, action codes, register indexes and shift amounts
module baro_compensation_sequencer_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [bcs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bcs_pkg::COEFF_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [bcs_pkg::SAMPLE_W-1:0]         raw_sample,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [bcs_pkg::OUT_W-1:0]     pressure,
    input  logic signed [bcs_pkg::OUT_W-1:0]     temperature,
    input  logic [bcs_pkg::ACT_W-1:0]            action,
    output int                                   n_errors,
    output int                                   n_pending,
    output int                                   n_press,
    output int                                   n_temp
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [bcs_pkg::OUT_W-1:0] pressure;
        logic signed [bcs_pkg::OUT_W-1:0] temperature;
        logic [bcs_pkg::ACT_W-1:0]        action;
    } reading_t;

    reading_t expected_readings [$];

    logic [bcs_pkg::COEFF_W-1:0]      coeff [0:bcs_pkg::REG_TEMP_SLOPE];
    logic [bcs_pkg::PHASE_W-1:0]      tick_count;
    logic                             temp_next;
    logic [bcs_pkg::SAMPLE_W-1:0]     raw_press;
    logic [bcs_pkg::SAMPLE_W-1:0]     raw_temp;
    logic signed [bcs_pkg::OUT_W-1:0] held_press;
    logic signed [bcs_pkg::OUT_W-1:0] held_temp;
    int                               errs;
    int                               presses;
    int                               temps;

    // one tick through the sequencer; compensation runs on the pressure action
    function automatic reading_t advance_tick(input logic [bcs_pkg::SAMPLE_W-1:0] sample);
        reading_t r;
        longint   dt;
        longint   temp_val;
        longint   off;
        longint   sens;
        longint   press;
        r.action = bcs_pkg::ACT_HOLD;
        if (int'(tick_count) >= bcs_pkg::TICKS_PER_READ - 1)
        begin
            tick_count = '0;
            if (!temp_next)
            begin
                raw_press = sample;
                dt = longint'(raw_temp)
                   - (longint'(coeff[bcs_pkg::REG_REF_TEMP]) <<< bcs_pkg::C5_SHIFT);
                temp_val = bcs_pkg::TEMP_BASE
                         + ((dt * longint'(coeff[bcs_pkg::REG_TEMP_SLOPE]))
                            >>> bcs_pkg::TEMP_SHIFT);
                off = (longint'(coeff[bcs_pkg::REG_OFFSET]) <<< bcs_pkg::C2_SHIFT)
                    + ((longint'(coeff[bcs_pkg::REG_OFFSET_TEMP]) * dt)
                       >>> bcs_pkg::OFF_SHIFT);
                sens = (longint'(coeff[bcs_pkg::REG_SENS]) <<< bcs_pkg::C1_SHIFT)
                     + ((longint'(coeff[bcs_pkg::REG_SENS_TEMP]) * dt)
                        >>> bcs_pkg::SENS_SHIFT);
                press = (((longint'(raw_press) * sens) >>> bcs_pkg::P_SHIFT_HI) - off)
                        >>> bcs_pkg::P_SHIFT_LO;
                held_temp = temp_val[bcs_pkg::OUT_W-1:0];
                held_press = press[bcs_pkg::OUT_W-1:0];
                temp_next = 1'b1;
                r.action = bcs_pkg::ACT_PRESS;
                presses++;
            end
            else
            begin
                raw_temp = sample;
                temp_next = 1'b0;
                r.action = bcs_pkg::ACT_TEMP;
                temps++;
            end
        end
        else
        begin
            tick_count = tick_count + 1'b1;
        end
        r.pressure = held_press;
        r.temperature = held_temp;
        return r;
    endfunction

    task automatic check_field(input string name,
                               input logic signed [bcs_pkg::OUT_W-1:0] want,
                               input logic signed [bcs_pkg::OUT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_t want;
        if (!rst_n)
        begin
            foreach (coeff[i]) coeff[i] = '0;
            tick_count = '0;
            temp_next = 1'b0;
            raw_press = '0;
            raw_temp = '0;
            held_press = '0;
            held_temp = '0;
            errs = 0;
            presses = 0;
            temps = 0;
            expected_readings.delete();
            n_errors <= 0;
            n_pending <= 0;
            n_press <= 0;
            n_temp <= 0;
        end
        else
        begin
            // indexes past the last register are dropped by the block
            if (cfg_valid && cfg_ready && cfg_index <= bcs_pkg::REG_TEMP_SLOPE)
                coeff[cfg_index] = cfg_data;
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: result with no tick pending: pressure %0d temperature %0d %s %0d",
                             $time, pressure, temperature, "action", action);
                    errs++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    check_field("pressure", want.pressure, pressure);
                    check_field("temperature", want.temperature, temperature);
                    check_field("action", {30'b0, want.action}, {30'b0, action});
                end
            end
            if (in_valid && in_ready)
                expected_readings.push_back(advance_tick(raw_sample));
            n_errors <= errs;
            n_pending <= expected_readings.size();
            n_press <= presses;
            n_temp <= temps;
        end
    end

endmodule

FILE: bench/baro_compensation_sequencer_tb.sv
// top of the baro_compensation_sequencer bench: clock, reset, coefficient writes, ticks,
// output back-pressure, watchdog and verdict
// depends on bcs_pkg, the block itself and baro_compensation_sequencer_checker
module baro_compensation_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 8;
    localparam int PHASES       = 7;
    localparam int PHASE_TICKS  = 190;
    localparam int LONG_HOLD    = 400;
    localparam int TAIL_CYCLES  = 120;
    localparam int STUCK_LIMIT  = 3000;

    typedef enum {SET_TYPICAL, SET_ZERO, SET_FULL, SET_RANDOM} coeff_set_t;

    localparam logic [bcs_pkg::COEFF_W-1:0] TYPICAL_COEFF [6] =
        '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};

    // every fourth tick acts: pressure first (raw temp still zero), then temp, and so on
    localparam logic [bcs_pkg::SAMPLE_W-1:0] OPENING_TICKS [24] = '{
        24'h000000, 24'hFFFFFF, 24'h800000, 24'd9085466,
        24'h7FFFFF, 24'h000001, 24'h555555, 24'd8569150,
        24'hAAAAAA, 24'h000000, 24'hFFFFFF, 24'd9085466,
        24'h123456, 24'h800000, 24'h7FFFFF, 24'hFFFFFF,
        24'h000000, 24'hFEDCBA, 24'h000001, 24'hFFFFFF,
        24'hFFFFFF, 24'h800000, 24'h000000, 24'h000000
    };

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [bcs_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [bcs_pkg::COEFF_W-1:0]       cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [bcs_pkg::SAMPLE_W-1:0]      raw_sample = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic signed [bcs_pkg::OUT_W-1:0]  pressure;
    logic signed [bcs_pkg::OUT_W-1:0]  temperature;
    logic [bcs_pkg::ACT_W-1:0]         action;

    int n_errors;
    int n_pending;
    int n_press;
    int n_temp;
    int ticks_sent = 0;
    int stuck_cycles = 0;
    bit steady_feed = 1'b0;

    always #5 clk = ~clk;

    baro_compensation_sequencer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .raw_sample  (raw_sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pressure    (pressure),
        .temperature (temperature),
        .action      (action)
    );

    baro_compensation_sequencer_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .raw_sample  (raw_sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pressure    (pressure),
        .temperature (temperature),
        .action      (action),
        .n_errors    (n_errors),
        .n_pending   (n_pending),
        .n_press     (n_press),
        .n_temp      (n_temp)
    );

    task automatic write_reg(input logic [bcs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bcs_pkg::COEFF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // writes all six coefficients, with one write to an unused index slipped in somewhere
    task automatic load_set(input coeff_set_t kind);
        logic [bcs_pkg::COEFF_W-1:0] value;
        int                          stray_at;
        stray_at = $urandom_range(0, bcs_pkg::REG_TEMP_SLOPE + 1);
        for (int r = 0; r <= bcs_pkg::REG_TEMP_SLOPE + 1; r++)
        begin
            if (r == stray_at)
                write_reg(bcs_pkg::CFG_IDX_W'(bcs_pkg::REG_TEMP_SLOPE + 1
                                              + $urandom_range(0, 1)),
                          bcs_pkg::COEFF_W'($urandom));
            if (r <= bcs_pkg::REG_TEMP_SLOPE)
            begin
                case (kind)
                    SET_TYPICAL: value = TYPICAL_COEFF[r];
                    SET_ZERO:    value = '0;
                    SET_FULL:    value = '1;
                    default:
                    begin
                        case ($urandom_range(0, 5))
                            0:       value = '0;
                            1:       value = '1;
                            default: value = bcs_pkg::COEFF_W'($urandom);
                        endcase
                    end
                endcase
                write_reg(bcs_pkg::CFG_IDX_W'(r), value);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(input logic [bcs_pkg::SAMPLE_W-1:0] sample);
        int gap;
        if (ticks_sent % 50 == 0)
            steady_feed = ($urandom_range(0, 3) == 0);
        gap = steady_feed ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_sample <= sample;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ticks_sent++;
    endtask

    // stop offering and wait until every predicted result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (n_pending != 0);
    endtask

    function automatic logic [bcs_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return bcs_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        coeff_set_t kind;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_set(SET_TYPICAL);
        foreach (OPENING_TICKS[k]) send_tick(OPENING_TICKS[k]);
        drain();
        for (int phase = 1; phase <= PHASES; phase++)
        begin
            case (phase)
                1:       kind = SET_ZERO;
                2:       kind = SET_FULL;
                default: kind = SET_RANDOM;
            endcase
            load_set(kind);
            for (int k = 0; k < PHASE_TICKS; k++)
            begin
                send_tick(pick_sample());
                if (phase == 4 && k == PHASE_TICKS / 2)
                    drain();
            end
            drain();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d ticks with %0d pressure and %0d temperature actions", ticks_sent,
                 n_press, n_temp);
        $display("over %0d coefficient sets, all-zero and all-ones among them", PHASES + 1);
        if (n_errors == 0 && n_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : result_sink
        int gap;
        int taken;
        bit eager;
        taken = 0;
        eager = 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (taken % 50 == 0)
                eager = ($urandom_range(0, 3) == 0);
            // a long hold now and then lets the block back up into its input
            if (taken % 300 == 150)
                gap = LONG_HOLD;
            else
                gap = eager ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: watchdog: no transfer in %0d cycles", $time, stuck_cycles);
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule
